FILE: rtl/meter_disk_mark_detector_macros.svh
`ifndef METER_DISK_MARK_DETECTOR_MACROS_SVH
`define METER_DISK_MARK_DETECTOR_MACROS_SVH

// same-cycle implication
`define MDMD_ASSERT_IMM(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MDMD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mdmd_pkg.sv
`default_nettype none
package mdmd_pkg;
   localparam int WINDOW_DEF = 16;
   localparam int AVG_DEF    = 300;
   localparam int BINS       = 1024;
   localparam int SAMPLE_W   = 10;
   localparam int WORD_W     = 32;
   localparam int KIND_W     = 2;
   localparam int ROT_W      = 16;
   localparam int TOL_W      = 8;
   localparam int THR_W      = 10;
   localparam int RUN_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int DIVS_W     = ROT_W + WORD_W;

   localparam logic [WORD_W-1:0] WATTS_NUM = 32'd3600000000;

   localparam logic [KIND_W-1:0] KIND_PULSE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_AVERAGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NEEDED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 3'd4;

   localparam logic [1:0] PH_PREWARM   = 2'd0;
   localparam logic [1:0] PH_STABILIZE = 2'd1;
   localparam logic [1:0] PH_UPHILL    = 2'd2;

   typedef struct packed {
      logic take;
      logic scan_step;
      logic decide;
      logic div_start;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic need_div;
      logic has_result;
      logic div_done;
   } sts_type;
endpackage
`default_nettype wire

FILE: rtl/mdmd_if.sv
`default_nettype none
interface mdmd_req_if import mdmd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [SAMPLE_W-1:0] sample;
   logic [WORD_W-1:0]   now_ms;
   modport source (output valid, mode, sample, now_ms, input ready);
   modport sink   (input valid, mode, sample, now_ms, output ready);
endinterface

interface mdmd_rsp_if import mdmd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [WORD_W-1:0] watts;
   logic [WORD_W-1:0] pulse_total;
   modport source (output valid, kind, watts, pulse_total, input ready);
   modport sink   (input valid, kind, watts, pulse_total, output ready);
endinterface

interface mdmd_csr_if import mdmd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/mdmd_div.sv
`default_nettype none
module mdmd_div import mdmd_pkg::*; #(
   parameter int DVD_W = 41,
   parameter int DVS_W = DIVS_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   shifted, trial;
   logic             ge;

   // restoring divide, one quotient bit a cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

FILE: rtl/mdmd_dp.sv
`default_nettype none
module mdmd_dp import mdmd_pkg::*; #(
   parameter int WINDOW          = WINDOW_DEF,
   parameter int AVERAGE_SECONDS = AVG_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output sts_type                   sts,
   input  wire logic                 req_mode,
   input  wire logic [SAMPLE_W-1:0]  req_sample,
   input  wire logic [WORD_W-1:0]    req_now_ms,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_data,
   output logic      [KIND_W-1:0]    rsp_kind,
   output logic      [WORD_W-1:0]    rsp_watts,
   output logic      [WORD_W-1:0]    rsp_pulse_total
);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SEEN_W = $clog2(WINDOW + 2);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SEC_W  = $clog2(AVERAGE_SECONDS + 1);
   localparam int SUM_W  = WORD_W + SEC_W;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(WINDOW);
   localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(AVERAGE_SECONDS);

   // configuration
   logic [ROT_W-1:0]  rot_ff;
   logic [TOL_W-1:0]  tol_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [RUN_W-1:0]  needed_ff;
   logic [WORD_W-1:0] timeout_ff;

   logic [SAMPLE_W-1:0] window_ff [WINDOW];
   logic [SLOT_W-1:0]   slot_ff, cand_ff;
   logic [SEEN_W-1:0]   seen_ff;
   logic [1:0]          phase_ff, phase_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic [WORD_W-1:0]   last_ff, last_in, count_ff, count_in, cw_ff, cw_in;
   logic                wvalid_ff, wvalid_in;
   logic [SEC_W-1:0]    sec_ff, sec_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                mode_ff;
   logic [SAMPLE_W-1:0] sample_ff, best_ff;
   logic [WORD_W-1:0]   now_ff;
   logic [CNT_W-1:0]    best_cnt_ff, match_cnt;
   logic [KIND_W-1:0]   pend_ff, pend_in;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic [WORD_W-1:0]   rsp_watts_ff, rsp_total_ff;

   logic [SAMPLE_W-1:0]       cand_val, diff;
   logic                      better;
   logic [SAMPLE_W+TOL_W-1:0] diff_q, tol_lim;
   logic [SAMPLE_W+THR_W:0]   up_lhs, up_rhs;
   logic                      stable_hit, uphill_hit, mark, timeout_hit, avg_go;
   logic [RUN_W-1:0]          run_inc;
   logic [WORD_W-1:0]         interval;
   logic [DIVS_W-1:0]         denom, dvs;
   logic [SEC_W-1:0]          sec_inc;
   logic [SUM_W-1:0]          sum_add, dvd, quo;
   logic [WORD_W-1:0]         quo_sat;
   logic                      div_done;

   // baseline scan: count matches of one window entry per cycle
   assign cand_val = window_ff[cand_ff];
   always_comb begin
      match_cnt = '0;
      for (int j = 0; j < WINDOW; j++) begin
         match_cnt = match_cnt + CNT_W'(window_ff[j] == cand_val);
      end
   end
   assign better = (32'(cand_val) < BINS) &&
                   ((match_cnt > best_cnt_ff) ||
                    ((match_cnt == best_cnt_ff) && (cand_val < best_ff)));

   // threshold tests against the baseline
   assign diff        = (sample_ff >= best_ff) ? sample_ff - best_ff : best_ff - sample_ff;
   assign diff_q      = {diff, 8'd0};
   assign tol_lim     = tol_ff * best_ff;
   assign stable_hit  = (best_ff != '0) && (diff_q <= tol_lim);
   assign run_inc     = run_ff + 1'b1;
   assign up_lhs      = (SAMPLE_W+THR_W+1)'({sample_ff, 8'd0});
   assign up_rhs      = best_ff * ((THR_W+1)'(256) + {1'b0, thr_ff});
   assign uphill_hit  = up_lhs > up_rhs;
   assign mark        = !mode_ff && (phase_ff == PH_UPHILL) && uphill_hit;
   assign interval    = now_ff - last_ff;
   assign timeout_hit = !mode_ff && !mark && (interval > timeout_ff);
   assign denom       = DIVS_W'(rot_ff) * DIVS_W'(interval);
   assign sec_inc     = sec_ff + 1'b1;
   assign sum_add     = sum_ff + SUM_W'(cw_ff);
   assign avg_go      = mode_ff && wvalid_ff && (sec_inc >= SEC_LAST);
   assign dvd         = mode_ff ? sum_add + SUM_W'(sec_inc >> 1) : SUM_W'(WATTS_NUM);
   assign dvs         = mode_ff ? DIVS_W'(sec_inc) : denom;

   mdmd_div #(.DVD_W(SUM_W), .DVS_W(DIVS_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo)
   );
   assign quo_sat = (|quo[SUM_W-1:WORD_W]) ? '1 : quo[WORD_W-1:0];

   assign sts.scan_last  = cand_ff == SLOT_LAST;
   assign sts.need_div   = mark || avg_go;
   assign sts.has_result = mark || avg_go || timeout_hit;
   assign sts.div_done   = div_done;

   always_comb begin
      phase_in  = phase_ff;
      run_in    = run_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      cw_in     = cw_ff;
      wvalid_in = wvalid_ff;
      sec_in    = sec_ff;
      sum_in    = sum_ff;
      pend_in   = pend_ff;
      if (cmd.decide) begin
         if (mode_ff) begin
            if (wvalid_ff) begin
               sec_in = sec_inc;
               sum_in = sum_add;
               if (avg_go) begin
                  sec_in  = '0;
                  sum_in  = '0;
                  pend_in = KIND_AVERAGE;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_PREWARM: begin
                  if (seen_ff > SEEN_FULL) phase_in = PH_STABILIZE;
               end
               PH_STABILIZE: begin
                  if (stable_hit) begin
                     run_in = run_inc;
                     if (run_inc >= needed_ff) begin
                        phase_in = PH_UPHILL;
                        run_in   = '0;
                     end
                  end
               end
               default: begin
                  if (mark) begin
                     phase_in  = PH_STABILIZE;
                     count_in  = count_ff + 1'b1;
                     last_in   = now_ff;
                     wvalid_in = 1'b1;
                     pend_in   = KIND_PULSE;
                  end
               end
            endcase
            if (timeout_hit) begin
               cw_in     = '0;
               wvalid_in = 1'b1;
               last_in   = now_ff;
               pend_in   = KIND_TIMEOUT;
            end
         end
      end
      if (cmd.load && (pend_ff == KIND_PULSE)) cw_in = quo_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff      <= ROT_W'(375);
         tol_ff      <= TOL_W'(13);
         thr_ff      <= THR_W'(26);
         needed_ff   <= RUN_W'(5);
         timeout_ff  <= WORD_W'(60000);
         for (int i = 0; i < WINDOW; i++) window_ff[i] <= '0;
         slot_ff     <= '0;
         seen_ff     <= '0;
         cand_ff     <= '0;
         best_ff     <= '0;
         best_cnt_ff <= '0;
         phase_ff    <= PH_PREWARM;
         run_ff      <= '0;
         last_ff     <= '0;
         count_ff    <= '0;
         cw_ff       <= '0;
         wvalid_ff   <= 1'b0;
         sec_ff      <= '0;
         sum_ff      <= '0;
         pend_ff     <= KIND_PULSE;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_ROT:     rot_ff     <= csr_data[ROT_W-1:0];
               REG_TOL:     tol_ff     <= csr_data[TOL_W-1:0];
               REG_THR:     thr_ff     <= csr_data[THR_W-1:0];
               REG_NEEDED:  needed_ff  <= csr_data[RUN_W-1:0];
               REG_TIMEOUT: timeout_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.take) begin
            cand_ff     <= '0;
            best_ff     <= '0;
            best_cnt_ff <= '0;
            if (!req_mode) begin
               window_ff[slot_ff] <= req_sample;
               slot_ff <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
               if (seen_ff <= SEEN_FULL) seen_ff <= seen_ff + 1'b1;
            end
         end else if (cmd.scan_step) begin
            cand_ff <= cand_ff + 1'b1;
            if (better) begin
               best_ff     <= cand_val;
               best_cnt_ff <= match_cnt;
            end
         end
         phase_ff  <= phase_in;
         run_ff    <= run_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
         cw_ff     <= cw_in;
         wvalid_ff <= wvalid_in;
         sec_ff    <= sec_in;
         sum_ff    <= sum_in;
         pend_ff   <= pend_in;
      end
      if (cmd.take) begin
         mode_ff   <= req_mode;
         sample_ff <= req_sample;
         now_ff    <= req_now_ms;
      end
      if (cmd.load) begin
         rsp_kind_ff  <= pend_ff;
         rsp_watts_ff <= (pend_ff == KIND_TIMEOUT) ? '0 : quo_sat;
         rsp_total_ff <= count_ff;
      end
   end

   assign rsp_kind        = rsp_kind_ff;
   assign rsp_watts       = rsp_watts_ff;
   assign rsp_pulse_total = rsp_total_ff;
endmodule
`default_nettype wire

FILE: rtl/mdmd_ctrl.sv
`default_nettype none
`include "meter_disk_mark_detector_macros.svh"
module mdmd_ctrl import mdmd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd,
   input  wire sts_type sts
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready     = state_ff == ST_IDLE;
   assign cmd.take      = req_valid && req_ready;
   assign cmd.scan_step = state_ff == ST_SCAN;
   assign cmd.decide    = state_ff == ST_DECIDE;
   assign cmd.div_start = cmd.decide && sts.need_div;
   assign cmd.load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (cmd.take) state_in = ST_SCAN;
         ST_SCAN:   if (sts.scan_last) state_in = ST_DECIDE;
         ST_DECIDE: begin
            priority if (sts.need_div) state_in = ST_DIV;
            else if (sts.has_result)   state_in = ST_EMIT;
            else                       state_in = ST_IDLE;
         end
         ST_DIV:    if (sts.div_done) state_in = ST_EMIT;
         ST_EMIT:   if (cmd.load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `MDMD_ASSERT_NXT(a_load_shows, clock, reset, cmd.load, rsp_valid_ff, "result not shown after load")
   `MDMD_ASSERT_IMM(a_done_in_div, clock, reset, sts.div_done, state_ff == ST_DIV, "divide ended outside wait")
   `MDMD_ASSERT_NXT(a_take_scans, clock, reset, cmd.take, state_ff == ST_SCAN, "item taken without scan")
endmodule
`default_nettype wire

FILE: rtl/meter_disk_mark_detector.sv
`default_nettype none
// channel  | dir | handshake         | payload
// req_ch   | in  | valid/ready       | mode, sample, now_ms
// rsp_ch   | out | valid/ready       | kind, watts, pulse_total
// csr_ch   | in  | valid/ready (=1)  | index, data
//
// one item at a time: the take, a baseline scan over all WINDOW entries and a decision;
// a result adds a load into the output register, and a mark or an average also adds a
// divide of 32+clog2(AVERAGE_SECONDS+1) quotient bits
// a waiting result sits in the output register; the next item is taken meanwhile
// and holds only at its own result until the old one is taken
// reset is synchronous and restores register defaults and the empty window
module meter_disk_mark_detector import mdmd_pkg::*; #(
   parameter int WINDOW          = WINDOW_DEF,
   parameter int AVERAGE_SECONDS = AVG_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mdmd_req_if.sink    req_ch,
   mdmd_rsp_if.source  rsp_ch,
   mdmd_csr_if.sink    csr_ch
);
   cmd_type cmd;
   sts_type sts;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   // sequencer: scan, decide, divide, present
   mdmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // window, baseline, mark state machine, watts and averaging
   mdmd_dp #(.WINDOW(WINDOW), .AVERAGE_SECONDS(AVERAGE_SECONDS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_ch.mode),
      .req_sample      (req_ch.sample),
      .req_now_ms      (req_ch.now_ms),
      .csr_write       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_kind        (rsp_ch.kind),
      .rsp_watts       (rsp_ch.watts),
      .rsp_pulse_total (rsp_ch.pulse_total)
   );
endmodule
`default_nettype wire
